// ===== rtl/fbpd_pkg.sv =====
// Shared constants, codes and control types of the frame-store primitive drawer.
`default_nettype none

package fbpd_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);

	localparam int MODE_W     = 3;
	localparam int COORD_W    = 6;
	localparam int SIZE_W     = 7;
	localparam int COLOR_W    = 32;
	localparam int COUNT_W    = 13;
	localparam int FRAC_BITS  = 16;
	localparam int DIV_W      = COORD_W + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int POS_W      = COORD_W + FRAC_BITS + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_PIXEL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RECT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LINE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FILL  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR    = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic div_step;
		logic draw_step;
		logic rd_issue;
		logic out_load;
	} fbpd_ctl_t;

	typedef struct packed {
		logic              clr_last;
		logic              div_last;
		logic              draw_last;
		logic              start_empty;
		logic [MODE_W-1:0] start_mode;
	} fbpd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fbpd_if.sv =====
// Request and result channel interfaces of the frame-store primitive drawer.
`default_nettype none

interface fbpd_cmd_if;
	import fbpd_pkg::*;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [COORD_W-1:0] first_x;
	logic [COORD_W-1:0] first_y;
	logic [COORD_W-1:0] second_x;
	logic [COORD_W-1:0] second_y;
	modport source (output valid, output mode, output first_x, output first_y,
		output second_x, output second_y, input ready);
	modport sink (input valid, input mode, input first_x, input first_y,
		input second_x, input second_y, output ready);
endinterface

interface fbpd_rsp_if;
	import fbpd_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] read_color;
	logic [COUNT_W-1:0] pixels_written;
	logic               clipped;
	modport source (output valid, output read_color, output pixels_written,
		output clipped, input ready);
	modport sink (input valid, input read_color, input pixels_written,
		input clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/fbpd_div.sv =====
// Restoring divider, one quotient bit per cycle while step is high, for the line step increments.
`default_nettype none

module fbpd_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [fbpd_pkg::COORD_W-1:0] num,
	input  logic [fbpd_pkg::COORD_W-1:0] den,
	output logic [fbpd_pkg::QUO_W-1:0]   quo
);
	import fbpd_pkg::*;

	logic [DIV_W-1:0]   num_q;
	logic [COORD_W-1:0] den_q;
	logic [COORD_W-1:0] rem_q;
	logic [DIV_W-1:0]   quo_q;
	logic [COORD_W:0]   rem_sh;
	logic [COORD_W:0]   rem_nx;
	logic               fits;

	always_comb begin
		rem_sh = {rem_q, num_q[DIV_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		rem_nx = fits ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= {num, {FRAC_BITS{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (step) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= rem_nx[COORD_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quo = quo_q[QUO_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/fbpd_datapath.sv =====
// Datapath: configuration registers, pixel walker, line stepper, frame store and result register.
`default_nettype none

module fbpd_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [fbpd_pkg::MODE_W-1:0]     mode,
	input  logic [fbpd_pkg::COORD_W-1:0]    first_x,
	input  logic [fbpd_pkg::COORD_W-1:0]    first_y,
	input  logic [fbpd_pkg::COORD_W-1:0]    second_x,
	input  logic [fbpd_pkg::COORD_W-1:0]    second_y,
	input  fbpd_pkg::fbpd_ctl_t             ctl,
	output fbpd_pkg::fbpd_sts_t             sts,
	output logic [fbpd_pkg::COLOR_W-1:0]    read_color,
	output logic [fbpd_pkg::COUNT_W-1:0]    pixels_written,
	output logic                           clipped
);
	import fbpd_pkg::*;

	logic [SIZE_W-1:0]    width_q;
	logic [SIZE_W-1:0]    height_q;
	logic [COLOR_W-1:0]   color_q;
	logic [SIZE_W-1:0]    eff_w;
	logic [SIZE_W-1:0]    eff_h;

	logic [SIZE_W-1:0]    nxs;
	logic [SIZE_W-1:0]    nxe;
	logic [SIZE_W-1:0]    nys;
	logic [SIZE_W-1:0]    nye;
	logic [COORD_W-1:0]   adx;
	logic [COORD_W-1:0]   ady;
	logic [COORD_W-1:0]   steps_n;
	logic                 empty_n;

	logic [MODE_W-1:0]    mode_q;
	logic [SIZE_W-1:0]    xs_q;
	logic [SIZE_W-1:0]    xe_q;
	logic [SIZE_W-1:0]    ye_q;
	logic [SIZE_W-1:0]    col_q;
	logic [SIZE_W-1:0]    row_q;
	logic [POS_W-1:0]     px_q;
	logic [POS_W-1:0]     py_q;
	logic [COORD_W-1:0]   steps_q;
	logic [COORD_W-1:0]   step_q;
	logic                 negx_q;
	logic                 negy_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 clip_q;
	logic                 rd_ok_q;
	logic [ADDR_W-1:0]    clr_q;

	logic [QUO_W-1:0]     quo_x;
	logic [QUO_W-1:0]     quo_y;
	logic [POS_W-1:0]     sx;
	logic [POS_W-1:0]     sy;
	logic                 is_line;
	logic [SIZE_W-1:0]    cx;
	logic [SIZE_W-1:0]    cy;
	logic                 in_area;
	logic [ADDR_W-1:0]    addr;
	logic                 col_wrap;

	logic [COLOR_W-1:0]   mem [0:DEPTH-1];
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [COLOR_W-1:0]   mem_wdata;
	logic [COLOR_W-1:0]   rdata_q;

	logic [COLOR_W-1:0]   read_color_q;
	logic [COUNT_W-1:0]   pixels_q;
	logic                 clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
			color_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_ACTIVE_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				REG_DRAW_COLOR:    color_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_w = (width_q > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_q;
	assign eff_h = (height_q > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_q;

	always_comb begin
		adx     = (second_x >= first_x) ? second_x - first_x : first_x - second_x;
		ady     = (second_y >= first_y) ? second_y - first_y : first_y - second_y;
		steps_n = (adx > ady) ? adx : ady;
		case (mode)
			MODE_RECT: begin
				nxs = SIZE_W'((first_x < second_x) ? first_x : second_x);
				nxe = SIZE_W'((first_x < second_x) ? second_x : first_x);
				nys = SIZE_W'((first_y < second_y) ? first_y : second_y);
				nye = SIZE_W'((first_y < second_y) ? second_y : first_y);
			end
			MODE_FILL: begin
				nxs = '0;
				nxe = eff_w;
				nys = '0;
				nye = eff_h;
			end
			default: begin
				nxs = SIZE_W'(first_x);
				nxe = SIZE_W'(first_x) + SIZE_W'(1);
				nys = SIZE_W'(first_y);
				nye = SIZE_W'(first_y) + SIZE_W'(1);
			end
		endcase
		case (mode)
			MODE_RECT: empty_n = (nxs == nxe) || (nys == nye);
			MODE_FILL: empty_n = (eff_w == '0) || (eff_h == '0);
			MODE_LINE: empty_n = (steps_n == '0);
			default:   empty_n = 1'b0;
		endcase
	end

	fbpd_div u_div_x (
		.clk  (clk),
		.load (ctl.load),
		.step (ctl.div_step),
		.num  (adx),
		.den  (steps_n),
		.quo  (quo_x)
	);

	fbpd_div u_div_y (
		.clk  (clk),
		.load (ctl.load),
		.step (ctl.div_step),
		.num  (ady),
		.den  (steps_n),
		.quo  (quo_y)
	);

	always_comb begin
		sx       = negx_q ? POS_W'(0) - POS_W'(quo_x) : POS_W'(quo_x);
		sy       = negy_q ? POS_W'(0) - POS_W'(quo_y) : POS_W'(quo_y);
		is_line  = (mode_q == MODE_LINE);
		cx       = is_line ? px_q[POS_W-1:FRAC_BITS] : col_q;
		cy       = is_line ? py_q[POS_W-1:FRAC_BITS] : row_q;
		in_area  = !cx[SIZE_W-1] && !cy[SIZE_W-1] && (cx < eff_w) && (cy < eff_h);
		addr     = ADDR_W'(cy[COORD_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx[COORD_W-1:0]);
		col_wrap = (SIZE_W'(col_q + SIZE_W'(1)) == xe_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			if (ctl.clr_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (ctl.load) begin
				div_cnt_q <= '0;
			end else if (ctl.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q  <= mode;
			xs_q    <= nxs;
			xe_q    <= nxe;
			ye_q    <= nye;
			col_q   <= nxs;
			row_q   <= nys;
			px_q    <= {1'b0, first_x, {FRAC_BITS{1'b0}}};
			py_q    <= {1'b0, first_y, {FRAC_BITS{1'b0}}};
			steps_q <= steps_n;
			step_q  <= '0;
			negx_q  <= second_x < first_x;
			negy_q  <= second_y < first_y;
			count_q <= '0;
			clip_q  <= 1'b0;
			rd_ok_q <= 1'b0;
		end else if (ctl.draw_step) begin
			count_q <= count_q + COUNT_W'(in_area);
			clip_q  <= clip_q | !in_area;
			if (is_line) begin
				px_q   <= px_q + sx;
				py_q   <= py_q + sy;
				step_q <= step_q + COORD_W'(1);
			end else if (col_wrap) begin
				col_q <= xs_q;
				row_q <= row_q + SIZE_W'(1);
			end else begin
				col_q <= col_q + SIZE_W'(1);
			end
		end else if (ctl.rd_issue) begin
			rd_ok_q <= in_area;
			clip_q  <= !in_area;
		end
	end

	always_comb begin
		sts.clr_last    = (clr_q == ADDR_W'(DEPTH - 1));
		sts.div_last    = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));
		sts.draw_last   = is_line ? (step_q == COORD_W'(steps_q - COORD_W'(1)))
			: (col_wrap && (SIZE_W'(row_q + SIZE_W'(1)) == ye_q));
		sts.start_empty = empty_n;
		sts.start_mode  = mode;
	end

	assign mem_we    = ctl.clr_step || (ctl.draw_step && in_area);
	assign mem_waddr = ctl.clr_step ? clr_q : addr;
	assign mem_wdata = ctl.clr_step ? '0 : color_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (ctl.rd_issue) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			read_color_q <= rd_ok_q ? rdata_q : '0;
			pixels_q     <= count_q;
			clipped_q    <= clip_q;
		end
	end

	assign read_color     = read_color_q;
	assign pixels_written = pixels_q;
	assign clipped        = clipped_q;

endmodule

`default_nettype wire

// ===== rtl/fbpd_ctrl.sv =====
// Controller state machine: clearing pass, request decode, division, drawing, read and result handoff.
`default_nettype none

module fbpd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fbpd_pkg::fbpd_sts_t sts,
	output fbpd_pkg::fbpd_ctl_t ctl
);
	import fbpd_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_DRAW  = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;

	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					if (sts.start_empty) begin
						state_nx = ST_DONE;
					end else begin
						case (sts.start_mode)
							MODE_PIXEL, MODE_RECT, MODE_FILL: state_nx = ST_DRAW;
							MODE_LINE: state_nx = ST_DIV;
							MODE_READ: state_nx = ST_READ;
							default:   state_nx = ST_DONE;
						endcase
					end
				end
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = ST_DRAW;
				end
			end
			ST_DRAW: begin
				ctl.draw_step = 1'b1;
				if (sts.draw_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_READ: begin
				ctl.rd_issue = 1'b1;
				state_nx     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/framebuffer_primitive_drawer.sv =====
// Top level of the frame-store primitive drawer: controller and datapath joined to the channels.
// After reset the frame store is swept to zero, one word a cycle, all 4096 words, before the first request is taken.
// A request visits N pixels, one per cycle with at most one frame-store write each: 1 for a pixel,
// the rectangle area, the active area for a fill; a line first runs a bit-serial division, then visits its step count.
// A read passes through the read and done states; the result register lets the next request enter while a result waits.
`default_nettype none

module framebuffer_primitive_drawer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpd_pkg::CFG_DATA_W-1:0] cfg_data,
	fbpd_cmd_if.sink                       cmd,
	fbpd_rsp_if.source                     rsp
);
	import fbpd_pkg::*;

	fbpd_ctl_t ctl;
	fbpd_sts_t sts;

	fbpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	fbpd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mode           (cmd.mode),
		.first_x        (cmd.first_x),
		.first_y        (cmd.first_y),
		.second_x       (cmd.second_x),
		.second_y       (cmd.second_y),
		.ctl            (ctl),
		.sts            (sts),
		.read_color     (rsp.read_color),
		.pixels_written (rsp.pixels_written),
		.clipped        (rsp.clipped)
	);

endmodule

`default_nettype wire

// ===== rtl/fbpd_checker.sv =====
// Port-level assertions for the frame-store primitive drawer and their bind to the top level.
`default_nettype none

module fbpd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [fbpd_pkg::COLOR_W-1:0] read_color,
	input logic [fbpd_pkg::COUNT_W-1:0] pixels_written,
	input logic                         clipped
);
	import fbpd_pkg::*;

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// Only one request is in work at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while another is in work");

	// A color read back comes only from a read, which writes and clips nothing.
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (read_color != '0) |-> (pixels_written == '0) && !clipped)
		else $error("read result carries a write count or clip flag");

	// No request writes more pixels than the frame store holds.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pixels_written <= COUNT_W'(DEPTH))
		else $error("pixel count above frame size");

endmodule

bind framebuffer_primitive_drawer fbpd_checker u_fbpd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.read_color     (rsp.read_color),
	.pixels_written (rsp.pixels_written),
	.clipped        (rsp.clipped)
);

`default_nettype wire
